// ----- rtl/relo_pkg.sv -----
`default_nettype none

package relo_pkg;

  // Ring geometry and field widths.
  localparam int unsigned RingDepth  = 16;
  localparam int unsigned LengthBits = 16;
  localparam int unsigned IdxW       = $clog2(RingDepth);
  localparam int unsigned CntW       = $clog2(RingDepth + 1);
  localparam int unsigned PosW       = 20;
  localparam int unsigned HandleW    = 32;

  // Operation codes of an input item.
  localparam logic OP_ADD    = 1'b0;
  localparam logic OP_LOOKUP = 1'b1;

  typedef struct packed {
    logic        op;
    logic [31:0] entry_handle;
    logic [15:0] entry_length;
    logic [19:0] byte_position;
  } in_item_t;

  typedef struct packed {
    logic        found;
    logic [3:0]  slot_index;
    logic [31:0] hit_handle;
    logic [15:0] hit_length;
    logic [15:0] offset_in_entry;
  } out_item_t;

  // Search token that travels from cell to cell around the ring.
  typedef struct packed {
    logic            valid;
    logic [PosW-1:0] pos;
    logic [CntW-1:0] left;
  } probe_t;

  // Result of one cell; all zero unless done is set.
  typedef struct packed {
    logic      done;
    out_item_t item;
  } cell_res_t;

endpackage

`default_nettype wire

// ----- rtl/relo_cell.sv -----
`default_nettype none

module relo_cell (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic [relo_pkg::IdxW-1:0]  idx_i,
  input  wire logic                       we_i,
  input  wire logic [relo_pkg::HandleW-1:0] handle_i,
  input  wire logic [relo_pkg::LengthBits-1:0] length_i,
  input  wire relo_pkg::probe_t           probe_i,
  output relo_pkg::probe_t                probe_o,
  output relo_pkg::cell_res_t             res_o
);
  import relo_pkg::*;

  logic [HandleW-1:0]    handle_q;
  logic [LengthBits-1:0] length_q;
  probe_t                probe_d, probe_q;
  cell_res_t             res_d, res_q;
  logic                  hit;
  logic                  exhausted;

  // Entry storage of this slot.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      handle_q <= handle_i;
      length_q <= length_i;
    end
  end

  // Test the arriving token against this entry.
  always_comb begin
    exhausted = (probe_i.left == '0);
    hit       = !exhausted && (probe_i.pos < PosW'(length_q));

    probe_d       = '0;
    probe_d.valid = probe_i.valid && !exhausted && !hit;
    probe_d.pos   = probe_i.pos - PosW'(length_q);
    probe_d.left  = probe_i.left - CntW'(1);

    res_d      = '0;
    res_d.done = probe_i.valid && (exhausted || hit);
    if (probe_i.valid && hit) begin
      res_d.item.found           = 1'b1;
      res_d.item.slot_index      = 4'(idx_i);
      res_d.item.hit_handle      = handle_q;
      res_d.item.hit_length      = 16'(length_q);
      res_d.item.offset_in_entry = probe_i.pos[15:0];
    end
  end

  // Hand the token on and hold the result for one cycle.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      probe_q <= '0;
      res_q   <= '0;
    end else begin
      probe_q <= probe_d;
      res_q   <= res_d;
    end
  end

  assign probe_o = probe_q;
  assign res_o   = res_q;

endmodule

`default_nettype wire

// ----- rtl/ring_entry_offset_locator_unit.sv -----
`default_nettype none

// Ring of entry descriptors with byte offset lookup.
// Input channel: an item is taken at a rising edge where start_i is high and
// busy_o is low. An add item (op = add) writes the next ring slot in that
// cycle, overwriting the oldest entry when the ring is full; it gives no
// result and busy_o stays low, so a further item may follow at once.
// A lookup item sends a search token into the cell holding the oldest entry.
// The token moves one cell per cycle around the ring of 16 cells, taking each
// entry's length off the remaining offset. The result appears on out_o with
// done_o high for one cycle, registered in the cell where the search ends,
// after the token has passed through the registers of the k cells whose
// entries it passes over (k = 0 .. 16, 16 when not found with a full ring).
// busy_o stays high until the cycle of that strobe, so the next item is taken
// at the earliest in the cycle after the result; no item is taken while a lookup is in flight.
// The receiver cannot stall: each result is valid for exactly one cycle.
// Reset empties the ring and drops any lookup in flight; slot contents are
// not cleared, since only entries written since reset are ever read.
module ring_entry_offset_locator_unit (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start_i,
  output logic                    busy_o,
  input  wire relo_pkg::in_item_t in_i,
  output logic                    done_o,
  output relo_pkg::out_item_t     out_o
);
  import relo_pkg::*;

  logic [IdxW-1:0] wp_q, wp_d;
  logic [IdxW-1:0] rp_q, rp_d;
  logic            full_q, full_d;
  logic            busy_q, busy_d;
  logic            accept;
  logic            do_add;
  logic            do_lookup;
  logic [CntW-1:0] count;
  probe_t          inject;

  probe_t          cell_in  [RingDepth];
  probe_t          cell_out [RingDepth];
  cell_res_t       cell_res [RingDepth];
  logic [RingDepth-1:0] cell_done;
  out_item_t       merged;

  assign accept    = start_i && !busy_q;
  assign do_add    = accept && (in_i.op == OP_ADD);
  assign do_lookup = accept && (in_i.op == OP_LOOKUP);

  // Number of valid entries in the ring.
  always_comb begin
    if (full_q) begin
      count = CntW'(RingDepth);
    end else if (wp_q >= rp_q) begin
      count = CntW'(wp_q) - CntW'(rp_q);
    end else begin
      count = CntW'(wp_q) + CntW'(RingDepth) - CntW'(rp_q);
    end
  end

  // Token sent into the ring by a lookup.
  always_comb begin
    inject       = '0;
    inject.valid = do_lookup;
    inject.pos   = in_i.byte_position;
    inject.left  = count;
  end

  // Pointer and flag update on an add.
  always_comb begin
    wp_d   = wp_q;
    rp_d   = rp_q;
    full_d = full_q;
    if (do_add) begin
      wp_d = (wp_q == IdxW'(RingDepth - 1)) ? '0 : wp_q + IdxW'(1);
      if (full_q) begin
        rp_d = (rp_q == IdxW'(RingDepth - 1)) ? '0 : rp_q + IdxW'(1);
      end
      full_d = full_q || (wp_d == rp_q);
    end
  end

  // The block is busy from a lookup's acceptance to its result.
  always_comb begin
    busy_d = busy_q;
    if (do_lookup) begin
      busy_d = 1'b1;
    end else if (done_o) begin
      busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q   <= '0;
      rp_q   <= '0;
      full_q <= 1'b0;
      busy_q <= 1'b0;
    end else begin
      wp_q   <= wp_d;
      rp_q   <= rp_d;
      full_q <= full_d;
      busy_q <= busy_d;
    end
  end

  // Ring of cells; the token enters at the oldest entry's cell.
  for (genvar k = 0; k < RingDepth; k++) begin : g_cell
    localparam int unsigned Prev = (k == 0) ? RingDepth - 1 : k - 1;

    assign cell_in[k] = (do_lookup && (rp_q == IdxW'(k))) ? inject : cell_out[Prev];

    relo_cell u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .idx_i    (IdxW'(k)),
      .we_i     (do_add && (wp_q == IdxW'(k))),
      .handle_i (in_i.entry_handle),
      .length_i (in_i.entry_length[LengthBits-1:0]),
      .probe_i  (cell_in[k]),
      .probe_o  (cell_out[k]),
      .res_o    (cell_res[k])
    );

    assign cell_done[k] = cell_res[k].done;
  end

  // At most one cell reports at a time; idle cells give zeros.
  always_comb begin
    merged = '0;
    for (int unsigned k = 0; k < RingDepth; k++) begin
      merged = merged | cell_res[k].item;
    end
  end

  assign busy_o = busy_q;
  assign done_o = |cell_done;
  assign out_o  = merged;

  // A single token means a single reporting cell.
  assert property (@(posedge clk_i) disable iff (!rst_ni) $onehot0(cell_done))
    else $error("more than one cell reported a result");

  // A result only ends a lookup that is in flight.
  assert property (@(posedge clk_i) disable iff (!rst_ni) done_o |-> busy_q)
    else $error("result strobe without a lookup in flight");

  // A full ring has its pointers together.
  assert property (@(posedge clk_i) disable iff (!rst_ni) full_q |-> (wp_q == rp_q))
    else $error("full ring with unequal pointers");

  // An accepted lookup keeps the input closed in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni) do_lookup |=> busy_o)
    else $error("busy not raised after a lookup was accepted");

endmodule

`default_nettype wire

// ----- verif/tb_ring_entry_offset_locator_unit.sv -----
`default_nettype none

module tb_ring_entry_offset_locator_unit;
  import relo_pkg::*;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      start_i = 1'b0;
  in_item_t  in_i = '0;
  logic      busy_o;
  logic      done_o;
  out_item_t out_o;

  ring_entry_offset_locator_unit u_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .busy_o  (busy_o),
    .in_i    (in_i),
    .done_o  (done_o),
    .out_o   (out_o)
  );

  always #5 clk_i = ~clk_i;

  // Items still to be offered, and lookup answers still to come back.
  in_item_t  pending_items_q[$];
  out_item_t lookup_answers_q[$];
  int unsigned err_count = 0;

  // Shadow copy of the ring, updated as each item is taken.
  logic [HandleW-1:0]    handle_ring[RingDepth];
  logic [LengthBits-1:0] len_ring[RingDepth];
  logic [IdxW-1:0]       wr_ptr = '0;
  logic [IdxW-1:0]       rd_ptr = '0;
  logic                  ring_full = 1'b0;

  // Lengths of the last 16 entries the stimulus has queued, oldest first.
  int unsigned queued_lens_q[$];

  int unsigned gap_left = 0;
  int unsigned calm_left = 0;

  // Apply one accepted item to the shadow ring; a lookup leaves its answer.
  task automatic track_ring_item(input in_item_t it);
    int unsigned     count;
    logic [IdxW-1:0] slot;
    logic [PosW-1:0] rest;
    out_item_t       hit;
    begin
      if (it.op == OP_ADD) begin
        if (ring_full) rd_ptr = rd_ptr + 1'b1;
        handle_ring[wr_ptr] = it.entry_handle;
        len_ring[wr_ptr] = it.entry_length;
        wr_ptr = wr_ptr + 1'b1;
        if (wr_ptr == rd_ptr) ring_full = 1'b1;
      end else begin
        hit = '0;
        count = ring_full ? RingDepth : int'(IdxW'(wr_ptr - rd_ptr));
        slot = rd_ptr;
        rest = it.byte_position;
        // Walk the valid entries oldest first; empty entries hold no bytes.
        for (int unsigned k = 0; k < count; k++) begin
          if (!hit.found) begin
            if (rest < PosW'(len_ring[slot])) begin
              hit.found = 1'b1;
              hit.slot_index = slot;
              hit.hit_handle = handle_ring[slot];
              hit.hit_length = len_ring[slot];
              hit.offset_in_entry = rest[15:0];
            end else begin
              rest = rest - PosW'(len_ring[slot]);
              slot = slot + 1'b1;
            end
          end
        end
        lookup_answers_q.push_back(hit);
      end
    end
  endtask

  function automatic int unsigned queued_total();
    int unsigned sum;
    begin
      sum = 0;
      foreach (queued_lens_q[k]) sum += queued_lens_q[k];
      return sum;
    end
  endfunction

  task automatic queue_add(input logic [31:0] handle, input logic [15:0] len);
    in_item_t it;
    begin
      it = '0;
      it.op = OP_ADD;
      it.entry_handle = handle;
      it.entry_length = len;
      it.byte_position = 20'($urandom);
      pending_items_q.push_back(it);
      queued_lens_q.push_back(32'(len));
      if (queued_lens_q.size() > RingDepth) void'(queued_lens_q.pop_front());
    end
  endtask

  task automatic queue_lookup(input logic [19:0] pos);
    in_item_t it;
    begin
      it.op = OP_LOOKUP;
      it.entry_handle = $urandom;
      it.entry_length = 16'($urandom);
      it.byte_position = pos;
      pending_items_q.push_back(it);
    end
  endtask

  function automatic logic [15:0] pick_length();
    begin
      case ($urandom_range(0, 9))
        0:       return 16'h0000;
        1:       return 16'hFFFF;
        2, 3:    return 16'($urandom);
        default: return 16'($urandom_range(1, 64));
      endcase
    end
  endfunction

  // Mostly offsets inside the stored data, with boundaries and wild values.
  function automatic logic [19:0] pick_position();
    int unsigned total;
    begin
      total = queued_total();
      case ($urandom_range(0, 9))
        0:       return 20'($urandom);
        1:       return (total > 20'hFFFFF) ? 20'hFFFFF : 20'(total);
        2:       return (total == 0) ? 20'h0 : 20'(total - 1);
        default: return (total == 0) ? 20'($urandom) : 20'($urandom_range(0, total - 1));
      endcase
    end
  endfunction

  // Gap after an item: mostly none or short, a few long, with calm stretches.
  function automatic int unsigned pick_gap();
    begin
      if (calm_left > 0) begin
        calm_left--;
        return 0;
      end
      if ($urandom_range(0, 19) == 0) calm_left = $urandom_range(10, 30);
      case ($urandom_range(0, 9))
        0:          return $urandom_range(10, 40);
        1, 2, 3:    return $urandom_range(1, 3);
        default:    return 0;
      endcase
    end
  endfunction

  function automatic in_item_t noise_item();
    in_item_t it;
    begin
      it.op = 1'($urandom);
      it.entry_handle = $urandom;
      it.entry_length = 16'($urandom);
      it.byte_position = 20'($urandom);
      return it;
    end
  endfunction

  // Driver: offers queued items and notes each one as it is taken.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      start_i <= 1'b0;
    end else begin
      if (start_i && !busy_o) begin
        track_ring_item(in_i);
      end
      if (!(start_i && busy_o)) begin
        if (gap_left > 0 || pending_items_q.size() == 0) begin
          if (gap_left > 0) gap_left--;
          start_i <= 1'b0;
          in_i <= noise_item();
        end else begin
          in_i <= pending_items_q.pop_front();
          start_i <= 1'b1;
          gap_left = pick_gap();
        end
      end
    end
  end

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    begin
      if (got !== want) begin
        $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
        err_count++;
      end
    end
  endtask

  // Monitor: every strobed result must match the oldest outstanding answer.
  always @(posedge clk_i) begin : result_monitor
    out_item_t want;
    if (rst_ni && done_o === 1'b1) begin
      if (lookup_answers_q.size() == 0) begin
        $display("%0t: result with no lookup outstanding, expected none, actual %h",
                 $time, out_o);
        err_count++;
      end else begin
        want = lookup_answers_q.pop_front();
        check_field("found", 32'(want.found), 32'(out_o.found));
        check_field("slot_index", 32'(want.slot_index), 32'(out_o.slot_index));
        check_field("hit_handle", want.hit_handle, out_o.hit_handle);
        check_field("hit_length", 32'(want.hit_length), 32'(out_o.hit_length));
        check_field("offset_in_entry", 32'(want.offset_in_entry),
                    32'(out_o.offset_in_entry));
      end
    end
  end

  // Stimulus, reset and end of run.
  initial begin
    // Lookups on an empty ring, then a ring holding only an empty entry.
    queue_lookup(20'h0);
    queue_add(32'h0000_0000, 16'h0000);
    queue_lookup(20'h0);
    // Extreme handles and lengths, with an empty entry between others.
    queue_add(32'hFFFF_FFFF, 16'hFFFF);
    queue_add(32'hA5A5_5A5A, 16'h0001);
    queue_add(32'h1234_5678, 16'h0000);
    queue_add(32'h0F0F_0F0F, 16'h0003);
    queue_lookup(20'h0);
    queue_lookup(20'h0FFFE);
    queue_lookup(20'h0FFFF);
    queue_lookup(20'h10000);
    queue_lookup(20'h10002);
    queue_lookup(20'h10003);
    queue_lookup(20'hFFFFF);
    // Fill the ring and overwrite the oldest entry.
    for (int k = 0; k < 12; k++) queue_add($urandom, 16'hFFFF);
    queue_lookup(20'(queued_total() - 1));
    queue_lookup(20'(queued_total()));

    for (int k = 0; k < 400; k++) begin
      if ($urandom_range(0, 99) < 45) queue_lookup(pick_position());
      else queue_add($urandom, pick_length());
    end

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending_items_q.size() != 0 || start_i) @(posedge clk_i);
    while (lookup_answers_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);

    if (err_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Watchdog well beyond the slowest correct run.
  initial begin
    #2000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

`default_nettype wire

// ----- files.f -----
rtl/relo_pkg.sv
rtl/relo_cell.sv
rtl/ring_entry_offset_locator_unit.sv
verif/tb_ring_entry_offset_locator_unit.sv
